// File: design/sha256_pkg.sv
// ----------------------------------------------------------------------------
// SHA-256 package
// Round constants, initial hash values, the round and schedule functions and
// the control groups shared between the engine's modules.
// ----------------------------------------------------------------------------
package sha256_pkg;

  localparam int unsigned WordW   = 32;
  localparam int unsigned Rounds  = 64;
  localparam int unsigned BlkWds  = 16;

  typedef logic [WordW-1:0] word_t;

  typedef struct packed {
    logic shift;
    logic from_round;
  } sched_ctl_t;

  typedef struct packed {
    logic load;
    logic step;
  } round_ctl_t;

  localparam word_t IV [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam word_t K [Rounds] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  localparam word_t PadWord = 32'h80000000;

  function automatic word_t rotr(input word_t v, input int unsigned k);
    rotr = (v >> k) | (v << (WordW - k));
  endfunction

  function automatic word_t big_s0(input word_t v);
    big_s0 = rotr(v, 2) ^ rotr(v, 13) ^ rotr(v, 22);
  endfunction

  function automatic word_t big_s1(input word_t v);
    big_s1 = rotr(v, 6) ^ rotr(v, 11) ^ rotr(v, 25);
  endfunction

  function automatic word_t small_s0(input word_t v);
    small_s0 = rotr(v, 7) ^ rotr(v, 18) ^ (v >> 3);
  endfunction

  function automatic word_t small_s1(input word_t v);
    small_s1 = rotr(v, 17) ^ rotr(v, 19) ^ (v >> 10);
  endfunction

endpackage

// File: design/sha256_hash_engine.sv
// ----------------------------------------------------------------------------
// SHA-256 hash engine
// Hashes a stream of big-endian words, pads the message and returns the
// 256-bit digest after the last word.
// ----------------------------------------------------------------------------
// Words are taken one per cycle while the engine is idle. The sixteenth
// word of a block starts a compression, one round per cycle in the shared
// round unit, and then the result is folded into the hash words. After the
// last word the engine inserts the pad and length words one per cycle and
// runs one or two further compressions before the digest appears. No request
// is taken while padding or compressing; a digest that has not been taken
// only stalls the end of the following message.
module sha256_hash_engine import sha256_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [39:0]  s_tdata,   // data_word[31:0], byte_count[34:32], zero
  input  logic         s_tlast,
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [255:0] m_tdata    // digest_part0, part1, part2, part3
);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_PAD   = 2'd1;
  localparam logic [1:0] ST_ROUND = 2'd2;
  localparam logic [1:0] ST_UPD   = 2'd3;

  logic [1:0]  state;
  logic [3:0]  pos;
  logic [5:0]  rnd;
  logic [63:0] bits;
  logic [63:0] bits_next;
  logic        tail;
  logic        pad_pending;
  logic        hi_done;
  logic        fin;
  word_t       hash [8];
  word_t       hsum [8];
  word_t       work [8];
  word_t       w0;
  word_t       app_word;
  word_t       last_word;
  logic        app;
  logic        acc;
  logic        out_free;
  logic [2:0]  nb;
  sched_ctl_t  sctl;
  round_ctl_t  rctl;

  assign s_tready = (state == ST_IDLE);
  assign acc      = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;
  assign nb       = (s_tdata[34:32] > 3'd4) ? 3'd4 : s_tdata[34:32];

  always_comb begin
    case (nb)
      3'd0:    last_word = PadWord;
      3'd1:    last_word = {s_tdata[31:24], 24'h800000};
      3'd2:    last_word = {s_tdata[31:16], 16'h8000};
      3'd3:    last_word = {s_tdata[31:8], 8'h80};
      default: last_word = s_tdata[31:0];
    endcase
  end

  always_comb begin
    if (s_tlast) begin
      bits_next = bits + {58'd0, nb, 3'd0};
    end else begin
      bits_next = bits + 64'd32;
    end
  end

  always_comb begin
    app      = 1'b0;
    app_word = '0;
    case (state)
      ST_IDLE: begin
        app      = acc;
        app_word = s_tlast ? last_word : s_tdata[31:0];
      end
      ST_PAD: begin
        app = 1'b1;
        if (pad_pending) begin
          app_word = PadWord;
        end else if (hi_done) begin
          app_word = bits[31:0];
        end else if (pos == 4'd14) begin
          app_word = bits[63:32];
        end
      end
      default: begin
        app = 1'b0;
      end
    endcase
  end

  always_comb begin
    for (int j = 0; j < 8; j++) begin
      hsum[j] = hash[j] + work[j];
    end
  end

  assign sctl.shift      = app || (state == ST_ROUND);
  assign sctl.from_round = (state == ST_ROUND);
  assign rctl.load       = app && (pos == 4'd15);
  assign rctl.step       = (state == ST_ROUND);

  sha256_sched u_sched (
    .clk (clk),
    .ctl (sctl),
    .din (app_word),
    .w0  (w0)
  );

  sha256_round u_round (
    .clk  (clk),
    .ctl  (rctl),
    .hash (hash),
    .kt   (K[rnd]),
    .wt   (w0),
    .work (work)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      pos         <= '0;
      rnd         <= '0;
      bits        <= '0;
      tail        <= 1'b0;
      pad_pending <= 1'b0;
      hi_done     <= 1'b0;
      fin         <= 1'b0;
      m_tvalid    <= 1'b0;
      hash        <= IV;
    end else begin
      if (m_tready && !(state == ST_UPD && fin)) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (acc) begin
            pos  <= pos + 4'd1;
            bits <= bits_next;
            if (s_tlast) begin
              tail        <= 1'b1;
              pad_pending <= (nb == 3'd4);
              hi_done     <= 1'b0;
              fin         <= 1'b0;
            end
            if (pos == 4'd15) begin
              rnd   <= '0;
              state <= ST_ROUND;
            end else if (s_tlast) begin
              state <= ST_PAD;
            end
          end
        end
        ST_PAD: begin
          pos <= pos + 4'd1;
          if (pad_pending) begin
            pad_pending <= 1'b0;
          end else if (hi_done) begin
            fin <= 1'b1;
          end else if (pos == 4'd14) begin
            hi_done <= 1'b1;
          end
          if (pos == 4'd15) begin
            rnd   <= '0;
            state <= ST_ROUND;
          end
        end
        ST_ROUND: begin
          rnd <= rnd + 6'd1;
          if (rnd == 6'd63) begin
            state <= ST_UPD;
          end
        end
        ST_UPD: begin
          if (fin) begin
            if (out_free) begin
              m_tvalid <= 1'b1;
              hash     <= IV;
              bits     <= '0;
              pos      <= '0;
              tail     <= 1'b0;
              hi_done  <= 1'b0;
              fin      <= 1'b0;
              state    <= ST_IDLE;
            end
          end else begin
            hash  <= hsum;
            state <= tail ? ST_PAD : ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_UPD && fin && out_free) begin
      for (int j = 0; j < 4; j++) begin
        m_tdata[64*j +: 64] <= {hsum[2*j], hsum[2*j+1]};
      end
    end
  end

  a_round_end: assert property (@(posedge clk) disable iff (rst)
    (state == ST_ROUND && rnd == 6'd63) |=> (state == ST_UPD))
    else $error("compression did not end after the last round");

  a_word_slot: assert property (@(posedge clk) disable iff (rst)
    (acc && !s_tlast && pos != 4'd15) |=>
      (state == ST_IDLE && pos == $past(pos) + 4'd1))
    else $error("plain word did not advance the block slot");

  a_len_slot: assert property (@(posedge clk) disable iff (rst)
    (state == ST_PAD && hi_done) |-> (pos == 4'd15))
    else $error("length low word not in the last slot");

  a_digest: assert property (@(posedge clk) disable iff (rst)
    (state == ST_UPD && fin && out_free) |=>
      (m_tvalid && bits == 64'd0 && pos == 4'd0 && state == ST_IDLE))
    else $error("digest not issued cleanly at message end");

  a_fin_pad: assert property (@(posedge clk) disable iff (rst)
    fin |-> (tail && hi_done && !pad_pending))
    else $error("finish flag set before the length words");

endmodule

// File: design/sha256_sched.sv
// ----------------------------------------------------------------------------
// SHA-256 message schedule
// Sixteen-word shift window: takes block words while loading and extends the
// schedule by one word per round while compressing.
// ----------------------------------------------------------------------------
module sha256_sched import sha256_pkg::*; (
  input  logic       clk,
  input  sched_ctl_t ctl,
  input  word_t      din,
  output word_t      w0
);

  word_t win [BlkWds];
  word_t ext;

  assign ext = small_s1(win[14]) + win[9] + small_s0(win[1]) + win[0];
  assign w0  = win[0];

  always_ff @(posedge clk) begin
    if (ctl.shift) begin
      for (int i = 0; i < BlkWds - 1; i++) begin
        win[i] <= win[i+1];
      end
      win[BlkWds-1] <= ctl.from_round ? ext : din;
    end
  end

endmodule

// File: design/sha256_round.sv
// ----------------------------------------------------------------------------
// SHA-256 round unit
// Working registers a to h and the single compression round, applied once
// per cycle while the step control is set.
// ----------------------------------------------------------------------------
module sha256_round import sha256_pkg::*; (
  input  logic       clk,
  input  round_ctl_t ctl,
  input  word_t      hash [8],
  input  word_t      kt,
  input  word_t      wt,
  output word_t      work [8]
);

  word_t t1;
  word_t t2;
  word_t ch;
  word_t maj;

  assign ch  = (work[4] & work[5]) ^ (~work[4] & work[6]);
  assign maj = (work[0] & work[1]) ^ (work[0] & work[2]) ^ (work[1] & work[2]);
  assign t1  = work[7] + big_s1(work[4]) + ch + kt + wt;
  assign t2  = big_s0(work[0]) + maj;

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      work <= hash;
    end else if (ctl.step) begin
      work[0] <= t1 + t2;
      work[1] <= work[0];
      work[2] <= work[1];
      work[3] <= work[2];
      work[4] <= work[3] + t1;
      work[5] <= work[4];
      work[6] <= work[5];
      work[7] <= work[6];
    end
  end

endmodule
